// ===== rtl/sip_pkg.sv =====
// Shared types, constants and coefficient tables for the selectable IIR prefilter.
`timescale 1ns / 1ps
package sip_pkg;

  localparam int SAMPLE_WIDTH      = 24;
  localparam int COEF_FRAC_BITS    = 27;
  localparam int HISTORY_FRAC_BITS = 8;

  localparam int Q30_FRAC   = 30;
  localparam int COEF_SHIFT = Q30_FRAC - COEF_FRAC_BITS;
  // largest coefficient magnitude is about 9.4: 4 integer bits plus sign
  localparam int COEF_W     = COEF_FRAC_BITS + 5;
  localparam int HIST_W     = SAMPLE_WIDTH + HISTORY_FRAC_BITS;
  localparam int PROD_W     = HIST_W + COEF_W;
  // eleven products: four bits of growth
  localparam int SUM_W      = PROD_W + 4;
  localparam int OUT_W      = HIST_W + 1;
  localparam int DEPTH      = 5;
  localparam int NUM_TAPS   = DEPTH + 1;

  localparam longint COEF_Q30_HALF = (longint'(1) << COEF_SHIFT) >> 1;
  localparam longint SUM_HALF      = (longint'(1) << COEF_FRAC_BITS) >> 1;
  localparam longint HIST_HALF     = (longint'(1) << HISTORY_FRAC_BITS) >> 1;
  localparam longint HIST_MAX      = (longint'(1) << (HIST_W - 1)) - 1;
  localparam longint HIST_MIN      = -(longint'(1) << (HIST_W - 1));
  localparam longint SMP_MAX       = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SMP_MIN       = -(longint'(1) << (SAMPLE_WIDTH - 1));

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [HIST_W-1:0]       hist_t;
  typedef logic signed [COEF_W-1:0]       coef_t;

  typedef enum logic [1:0] {
    FILT_HIGHPASS = 2'd0,
    FILT_LOWPASS  = 2'd1,
    FILT_NOTCH    = 2'd2
  } filter_e;

  // selector code with no filter behind it; writes of it are dropped
  localparam logic [1:0] FILT_CODE_RSVD = 2'd3;

  typedef struct packed {
    hist_t   y_hist;   // y[n] with fraction bits, fed back
    sample_t sample;   // rounded, saturated output sample
    logic    clipped;
  } mac_res_t;

  localparam longint NUM_Q30 [3][NUM_TAPS] = '{
    '{ 994905822, -64'sd4974529110, 64'sd9949058220, -64'sd9949058220,
       64'sd4974529110, -994905822 },
    '{ 7444463, 37222315, 74444630, 74444630, 37222315, 7444463 },
    '{ 1068404337, -2135161272, 1068404337, 0, 0, 0 }
  };

  localparam longint DEN_Q30 [3][DEPTH] = '{
    '{ -64'sd5204972086, 64'sd10094884976, -64'sd9791662852, 64'sd4749866466,
       -921858097 },
    '{ -2121608206, 64'sd2161950200, -1183927039, 351777508, -43711482 },
    '{ -2135161272, 1063066850, 0, 0, 0 }
  };

  // round half up from 30 fraction bits to COEF_FRAC_BITS
  function automatic coef_t coef_round(longint c30);
    longint r;
    r = (c30 + COEF_Q30_HALF) >>> COEF_SHIFT;
    return coef_t'(r);
  endfunction

  function automatic int unsigned set_idx(filter_e sel);
    int unsigned i;
    case (sel)
      FILT_HIGHPASS: i = 0;
      FILT_LOWPASS:  i = 1;
      FILT_NOTCH:    i = 2;
      default:       i = 2;
    endcase
    return i;
  endfunction

  function automatic coef_t num_coef(filter_e sel, int unsigned k);
    return coef_round(NUM_Q30[set_idx(sel)][k]);
  endfunction

  // feedback taps enter the sum negated; rounded first, so a tie goes up before the flip
  function automatic coef_t den_coef_neg(filter_e sel, int unsigned k);
    return -coef_round(DEN_Q30[set_idx(sel)][k]);
  endfunction

endpackage

// ===== rtl/sip_mac.sv =====
// Eleven-tap direct-form-I sum with rounding and saturation for one sample.
`timescale 1ns / 1ps
module sip_mac import sip_pkg::*; (
  input  filter_e  sel_i,
  input  sample_t  x_i,
  input  sample_t  x_hist_i [DEPTH],
  input  hist_t    y_hist_i [DEPTH],
  output mac_res_t res_o
);

  localparam logic signed [SUM_W-1:0] SumHalf = SUM_W'(SUM_HALF);
  localparam logic signed [SUM_W-1:0] YMax    = SUM_W'(HIST_MAX);
  localparam logic signed [SUM_W-1:0] YMin    = SUM_W'(HIST_MIN);
  localparam logic signed [OUT_W-1:0] OHalf   = OUT_W'(HIST_HALF);
  localparam logic signed [OUT_W-1:0] OMax    = OUT_W'(SMP_MAX);
  localparam logic signed [OUT_W-1:0] OMin    = OUT_W'(SMP_MIN);

  logic signed [PROD_W-1:0] prod [NUM_TAPS + DEPTH];
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  y_wide;
  hist_t                    y_sat;
  logic                     y_clip;
  logic signed [OUT_W-1:0]  o_sum;
  logic signed [OUT_W-1:0]  o_wide;
  sample_t                  o_sat;
  logic                     o_clip;

  // feed-forward taps on x scaled to history fraction bits, then feedback taps
  always_comb begin
    prod[0] = PROD_W'(hist_t'(x_i) <<< HISTORY_FRAC_BITS) * PROD_W'(num_coef(sel_i, 0));
    for (int k = 1; k < NUM_TAPS; k++) begin
      prod[k] = PROD_W'(hist_t'(x_hist_i[k-1]) <<< HISTORY_FRAC_BITS)
              * PROD_W'(num_coef(sel_i, k));
    end
    for (int k = 0; k < DEPTH; k++) begin
      prod[NUM_TAPS+k] = PROD_W'(y_hist_i[k]) * PROD_W'(den_coef_neg(sel_i, k));
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_TAPS + DEPTH; k++) begin
      acc = acc + SUM_W'(prod[k]);
    end
  end

  // round half up to history precision, saturate to history width
  always_comb begin
    y_wide = (acc + SumHalf) >>> COEF_FRAC_BITS;
    y_clip = 1'b0;
    if (y_wide > YMax) begin
      y_sat  = hist_t'(HIST_MAX);
      y_clip = 1'b1;
    end else if (y_wide < YMin) begin
      y_sat  = hist_t'(HIST_MIN);
      y_clip = 1'b1;
    end else begin
      y_sat  = y_wide[HIST_W-1:0];
    end
  end

  // round half up to an integer sample, saturate to sample width
  always_comb begin
    o_sum  = OUT_W'(y_sat) + OHalf;
    o_wide = o_sum >>> HISTORY_FRAC_BITS;
    o_clip = 1'b0;
    if (o_wide > OMax) begin
      o_sat  = sample_t'(SMP_MAX);
      o_clip = 1'b1;
    end else if (o_wide < OMin) begin
      o_sat  = sample_t'(SMP_MIN);
      o_clip = 1'b1;
    end else begin
      o_sat  = o_wide[SAMPLE_WIDTH-1:0];
    end
  end

  assign res_o.y_hist  = y_sat;
  assign res_o.sample  = o_sat;
  assign res_o.clipped = y_clip | o_clip;

endmodule

// ===== rtl/selectable_iir_prefilter.sv =====
// Top level of the selectable IIR prefilter: handshake, history registers, result register.
//
// Usage:
//  - Input channel: sample_in_i with in_valid_i / in_ready_o. An item is taken
//    when both are high at a rising edge of clk_i.
//  - Output channel: sample_out_o and clipped_o with out_valid_o / out_ready_i.
//  - filter_select_i is written when filter_select_we_i is high: 0 high-pass
//    80 Hz, 1 low-pass 1200 Hz, 2 notch 50 Hz. A write of 0..2 also clears the
//    input and output histories; a write of 3 is dropped. Write only while the
//    block holds no items.
//  - Path: an accepted item goes to the input register, then its result goes
//    to the result register and out_valid_o rises. Throughput: one item per
//    cycle while the receiver takes each result, set by the feedback through
//    the eleven-tap sum in sip_mac.
//  - Stall: when out_ready_i is low with a result waiting, the item in the
//    input register holds and in_ready_o drops; up to two items sit in the block.
//  - Reset (rst_ni low, async): selection goes to high-pass, both histories
//    clear, no items are held.
//
`timescale 1ns / 1ps
module selectable_iir_prefilter import sip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    filter_select_we_i,
  input  logic [1:0]              filter_select_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                    clipped_o
);

  filter_e  sel_q;
  logic     s0_valid_q;
  sample_t  x_q;
  sample_t  xh_q [DEPTH];
  hist_t    yh_q [DEPTH];
  logic     out_valid_q;
  sample_t  sample_q;
  logic     clip_q;
  mac_res_t res;
  logic     advance;
  logic     accept;
  logic     cfg_take;

  // item in the input register moves on when the result register frees up
  assign advance    = s0_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_take   = filter_select_we_i && (filter_select_i != FILT_CODE_RSVD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (accept) begin
      s0_valid_q <= 1'b1;
    end else if (advance) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_t'(sample_in_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= FILT_HIGHPASS;
    end else if (cfg_take) begin
      sel_q <= filter_e'(filter_select_i);
    end
  end

  // histories: cleared on reset and on a selector write, shifted per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        xh_q[k] <= '0;
        yh_q[k] <= '0;
      end
    end else if (cfg_take) begin
      for (int k = 0; k < DEPTH; k++) begin
        xh_q[k] <= '0;
        yh_q[k] <= '0;
      end
    end else if (advance) begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        xh_q[k] <= xh_q[k-1];
        yh_q[k] <= yh_q[k-1];
      end
      xh_q[0] <= x_q;
      yh_q[0] <= res.y_hist;
    end
  end

  sip_mac u_mac (
    .sel_i    (sel_q),
    .x_i      (x_q),
    .x_hist_i (xh_q),
    .y_hist_i (yh_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q <= res.sample;
      clip_q   <= res.clipped;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign clipped_o    = clip_q;

`ifndef SYNTHESIS
  // a selector write leaves both histories empty
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_take |=> (xh_q[0] == '0) && (yh_q[0] == '0) && (xh_q[DEPTH-1] == '0))
    else $error("history not cleared after selector write");

  // full pipe with a stalled receiver must refuse input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages are blocked");

  // an item that leaves the input register lands in history tap zero
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !cfg_take) |=> (xh_q[0] == $past(x_q)) && out_valid_o)
    else $error("history or result register missed an item");
`endif

endmodule

// ===== sim/selectable_iir_prefilter_tb.sv =====
// Self-checking testbench for the selectable IIR prefilter: directed rows, then random phases.
`timescale 1ns / 1ps
module selectable_iir_prefilter_tb;
  import sip_pkg::*;

  // cycles with no handshake and no register write before the run is declared hung
  localparam int HANG_LIMIT  = 1000;
  // long receiver hold-off, enough to fill both internal stages and stall the input
  localparam int HOLD_CYCLES = 120;
  // margin after the last owed result before a register write or the end
  localparam int SETTLE      = 4;
  localparam int TARGET_ITEMS = 1850;
  // no idling on either side once this many items are left
  localparam int CALM_TAIL   = 150;
  localparam int MAX_PRINTS  = 40;

  // one filtered sample as it should leave the block
  typedef struct packed {
    sample_t s;
    logic    clip;
  } out_item_t;

  // per offered item: whether the expected result is typed in the directed rows
  typedef struct packed {
    logic    known;
    sample_t y;
    logic    clip;
  } typed_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] sel;
    sample_t    x;
    logic       known;
    sample_t    y;
    logic       clip;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    filter_select_we_i;
  logic [1:0]              filter_select_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [SAMPLE_WIDTH-1:0] sample_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [SAMPLE_WIDTH-1:0] sample_out_o;
  logic                    clipped_o;

  selectable_iir_prefilter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .filter_select_we_i (filter_select_we_i),
    .filter_select_i    (filter_select_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_in_i        (sample_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sample_out_o       (sample_out_o),
    .clipped_o          (clipped_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow filter state, stepped at every accepted item
  // ---------------------------------------------------------------------------
  filter_e   shadow_sel = FILT_HIGHPASS;
  sample_t   x_hist [DEPTH];
  hist_t     y_hist [DEPTH];

  out_item_t pending_out [$];  // results still owed by the block, oldest first
  typed_t    typed_q [$];      // typed-in expectations, one per offered item
  stim_row_t dir_rows [$];

  int  mismatch_cnt = 0;
  int  sent_cnt     = 0;
  bit  calm         = 1'b0;
  bit  hold_req     = 1'b0;

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
  end

  // coefficient from 30 fraction bits to COEF_FRAC_BITS, half rounded up
  function automatic longint coef_q(longint c30);
    int d;
    d = Q30_FRAC - COEF_FRAC_BITS;
    if (d == 0) return c30;
    return (c30 + (longint'(1) << (d - 1))) >>> d;
  endfunction

  // Direct-form-I step. Products are exact (64 bit each), the sum is kept
  // 96 bits wide so nothing wraps before the rounding shift.
  // Feedback taps: the rounded denominator coefficient is negated, so a tie
  // rounds toward +inf before the sign flip.
  task automatic filter_step(input sample_t x, output sample_t y_o, output logic clip_o);
    logic signed [95:0] acc;
    logic signed [95:0] term;
    longint c;
    longint v;
    longint yl;
    longint ol;
    int     set;
    acc    = '0;
    clip_o = 1'b0;
    set    = (shadow_sel == FILT_LOWPASS) ? 1 : (shadow_sel == FILT_NOTCH) ? 2 : 0;
    for (int k = 0; k < 2 * DEPTH + 1; k++) begin
      if (k < NUM_TAPS) begin
        v = longint'((k == 0) ? x : x_hist[k-1]) * (longint'(1) << HISTORY_FRAC_BITS);
        c = coef_q(NUM_Q30[set][k]);
      end else begin
        v = longint'(y_hist[k-NUM_TAPS]);
        c = -coef_q(DEN_Q30[set][k-NUM_TAPS]);
      end
      term = c * v;
      acc  = acc + term;
    end
    acc = acc + (96'sd1 <<< (COEF_FRAC_BITS - 1));
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > HIST_MAX) begin
      yl = HIST_MAX;
      clip_o = 1'b1;
    end else if (acc < HIST_MIN) begin
      yl = HIST_MIN;
      clip_o = 1'b1;
    end else begin
      yl = longint'(acc);
    end
    for (int k = DEPTH - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = hist_t'(yl);
    // output: drop the history fraction bits, half up, then clamp
    ol = (yl + HIST_HALF) >>> HISTORY_FRAC_BITS;
    if (ol > SMP_MAX) begin
      ol = SMP_MAX;
      clip_o = 1'b1;
    end else if (ol < SMP_MIN) begin
      ol = SMP_MIN;
      clip_o = 1'b1;
    end
    y_o = sample_t'(ol);
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: check results first, then step the shadow filter for any
  // register write or accepted item at this edge. Values read here are the
  // ones from before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    out_item_t e;
    typed_t    t;
    sample_t   py;
    logic      pc;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_out.size() == 0) begin
          flag_mismatch("unexpected item", {8'h0, sample_out_o}, '0);
        end else begin
          e = pending_out.pop_front();
          if (sample_out_o !== e.s)
            flag_mismatch("sample_out", {8'h0, sample_out_o}, {8'h0, e.s});
          if (clipped_o !== e.clip)
            flag_mismatch("clipped", {31'h0, clipped_o}, {31'h0, e.clip});
        end
      end
      // a write of the reserved code leaves selection and history alone
      if (filter_select_we_i && filter_select_i != FILT_CODE_RSVD) begin
        shadow_sel = filter_e'(filter_select_i);
        for (int k = 0; k < DEPTH; k++) begin
          x_hist[k] = '0;
          y_hist[k] = '0;
        end
      end
      if (in_valid_i && in_ready_o) begin
        filter_step(sample_t'(sample_in_i), py, pc);
        t = typed_q.pop_front();
        if (t.known) begin
          e.s    = t.y;
          e.clip = t.clip;
        end else begin
          e.s    = py;
          e.clip = pc;
        end
        pending_out.push_back(e);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hang detector: any handshake or register write restarts the count
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          filter_select_we_i || !rst_ni)
        idle = 0;
      else
        idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, ready stretches, and on request one long
  // hold-off so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one item and hold it until taken; sometimes drop valid for a burst.
  task automatic offer_sample(sample_t x, logic known, sample_t ty, logic tc);
    typed_t t;
    t.known = known;
    t.y     = ty;
    t.clip  = tc;
    typed_q.push_back(t);
    sample_in_i <= x;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Register write with the block empty: stop offering, wait for every owed
  // result, let the pipeline settle, then pulse the write enable.
  task automatic write_select(logic [1:0] code);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    filter_select_i    <= code;
    filter_select_we_i <= 1'b1;
    @(posedge clk_i);
    filter_select_we_i <= 1'b0;
  endtask

  function automatic stim_row_t mk_row(logic is_cfg, logic [1:0] sel, sample_t x,
                                       logic known, sample_t y, logic clip);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.sel    = sel;
    r.x      = x;
    r.known  = known;
    r.y      = y;
    r.clip   = clip;
    return r;
  endfunction

  initial begin : stimulus
    sample_t smp_max;
    sample_t smp_min;
    sample_t x;
    logic [1:0] code;
    int phase_len;
    int mode;
    int m;
    int half_per;
    int amp_bits;
    int amp;
    int a;

    smp_max = sample_t'(SMP_MAX);
    smp_min = sample_t'(SMP_MIN);

    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    sample_in_i        <= '0;
    filter_select_we_i <= 1'b0;
    filter_select_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows. A zero input on cleared history gives zero out, no clip;
    // those are typed in, the rest go through the shadow filter.
    dir_rows.push_back(mk_row(1'b0, '0, '0, 1'b1, '0, 1'b0));     // high-pass after reset
    dir_rows.push_back(mk_row(1'b0, '0, '0, 1'b1, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_max, 1'b0, '0, 1'b0));
    // full-scale swings through the high-pass overrun the sample range
    dir_rows.push_back(mk_row(1'b0, '0, smp_min, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_max, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_min, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, sample_t'(1), 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, sample_t'(-1), 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b1, FILT_LOWPASS, '0, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, '0, 1'b1, '0, 1'b0));     // history cleared by write
    // full-scale step: low-pass overshoot, output saturates at the top
    for (int i = 0; i < 6; i++)
      dir_rows.push_back(mk_row(1'b0, '0, smp_max, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b1, FILT_NOTCH, '0, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, '0, 1'b1, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_min, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_min, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, smp_max, 1'b0, '0, 1'b0));
    // reserved selector: notch and its history carry on
    dir_rows.push_back(mk_row(1'b1, FILT_CODE_RSVD, '0, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, sample_t'(-1), 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, sample_t'(24'h5a5a5a), 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, sample_t'(24'ha5a5a5), 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b1, FILT_HIGHPASS, '0, 1'b0, '0, 1'b0));
    dir_rows.push_back(mk_row(1'b0, '0, '0, 1'b1, '0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_select(dir_rows[i].sel);
      else
        offer_sample(dir_rows[i].x, dir_rows[i].known, dir_rows[i].y, dir_rows[i].clip);
    end

    // Random phases: each starts with a register write (reserved code now
    // and then), then a run of samples in one signal style.
    //   0: any 24-bit value   1: small amplitude   2: extremes and near zero
    //   3: square wave of random period and amplitude   4: per-item mix
    while (sent_cnt < TARGET_ITEMS) begin
      m    = $urandom_range(0, 7);
      code = (m == 7) ? FILT_CODE_RSVD : 2'(m % 3);
      write_select(code);
      phase_len = $urandom_range(30, 200);
      mode      = $urandom_range(0, 4);
      half_per  = $urandom_range(1, 40);
      amp_bits  = $urandom_range(4, 23);
      amp       = (1 << amp_bits) - 1;
      if (!calm && (sent_cnt < 200 || $urandom_range(0, 3) == 0))
        hold_req = 1'b1;
      for (int i = 0; i < phase_len && sent_cnt < TARGET_ITEMS; i++) begin
        calm = (sent_cnt >= TARGET_ITEMS - CALM_TAIL);
        m = (mode == 4) ? $urandom_range(0, 3) : mode;
        case (m)
          0: x = sample_t'($urandom);
          1: begin
            a = 1 << $urandom_range(0, 12);
            x = sample_t'(int'($urandom_range(0, 2 * a)) - a);
          end
          2: begin
            case ($urandom_range(0, 4))
              0: x = smp_max;
              1: x = smp_min;
              2: x = '0;
              3: x = sample_t'(1);
              default: x = sample_t'(-1);
            endcase
          end
          default: x = ((i / half_per) % 2 == 0) ? sample_t'(amp) : sample_t'(-amp);
        endcase
        offer_sample(x, 1'b0, '0, 1'b0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
